>>> rtl/ute_pkg.sv
// Shared types, constants and helpers of the unique trigram extractor.
package ute_pkg;

  localparam int ALPHABET_SIZE = 95;
  localparam int MAP_BITS      = ALPHABET_SIZE * ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int BYTE_W        = 8;
  localparam int CHAR_W        = 7;
  localparam int IDX_W         = $clog2(MAP_BITS);
  localparam int COUNT_W       = 20;

  localparam logic [BYTE_W-1:0] FIRST_PRINTABLE = 8'h20;
  localparam logic [BYTE_W-1:0] UPPER_A         = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_Z         = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET     = 8'h20;

  localparam int WORD_BITS = 64;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WORDS     = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = $clog2(WORDS);

  localparam int EP_W = 8;
  localparam logic [EP_W-1:0] EP_CLEAN = {EP_W{1'b1}};
  localparam logic [EP_W-1:0] EP_LAST  = EP_CLEAN - EP_W'(1);
  localparam int ENTRY_W = EP_W + WORD_BITS;

  localparam int MID_DEPTH = 4;
  localparam int MQ_PTR_W  = $clog2(MID_DEPTH);
  localparam int MQ_CNT_W  = $clog2(MID_DEPTH + 1);
  localparam int OUT_DEPTH = 4;
  localparam int OQ_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OQ_CNT_W  = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [CHAR_W-1:0] t0;
    logic [CHAR_W-1:0] t1;
    logic [CHAR_W-1:0] t2;
    logic              cand;
    logic              first;
    logic              last;
  } mid_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  t0;
    logic [CHAR_W-1:0]  t1;
    logic [CHAR_W-1:0]  t2;
    logic               valid;
    logic               eob;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= UPPER_A && c <= UPPER_Z) r = c + CASE_OFFSET;
    return r;
  endfunction

  function automatic logic is_printable(input logic [BYTE_W-1:0] c);
    return (c >= FIRST_PRINTABLE) && (c < FIRST_PRINTABLE + BYTE_W'(ALPHABET_SIZE));
  endfunction

  function automatic logic [CHAR_W-1:0] digit_of(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] d;
    d = c - FIRST_PRINTABLE;
    return d[CHAR_W-1:0];
  endfunction

endpackage

>>> rtl/unique_trigram_extractor.sv
// Top level of the unique trigram extractor.
// Takes one byte per cycle while in_full is low and gives one result per new
// trigram or buffer end, in order. A byte passes the front queue, the map read
// and then the map test-and-set before its result enters the result queue,
// where it can be popped at the next edge. The map is a 13397 x 72 RAM of 64-bit
// words, each tagged with an 8-bit buffer epoch, so a new buffer needs no clear.
// The RAM's single write port sets the pace: a clearing sweep of all 13397 words
// runs after reset and again before the 255th buffer that follows a sweep, and
// no byte leaves the front queue during it.
module unique_trigram_extractor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ute_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                        in_first_of_buffer,
  input  logic                        in_last_of_buffer,
  input  logic                        in_push,
  output logic                        in_full,
  output logic [ute_pkg::CHAR_W-1:0]  out_tri_first,
  output logic [ute_pkg::CHAR_W-1:0]  out_tri_second,
  output logic [ute_pkg::CHAR_W-1:0]  out_tri_third,
  output logic                        out_trigram_valid,
  output logic                        out_end_of_buffer,
  output logic [ute_pkg::COUNT_W-1:0] out_unique_count,
  output logic                        out_empty,
  input  logic                        out_pop
);
  import ute_pkg::*;

  logic      q_full, q_push, head_valid, head_pop;
  mid_item_t q_item, head;

  ute_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_data_byte      (in_data_byte),
    .in_first_of_buffer(in_first_of_buffer),
    .in_last_of_buffer (in_last_of_buffer),
    .in_push           (in_push),
    .in_full           (in_full),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_item            (q_item)
  );

  ute_mid_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .item_in   (q_item),
    .full      (q_full),
    .pop       (head_pop),
    .head_valid(head_valid),
    .head      (head)
  );

  ute_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head             (head),
    .head_pop         (head_pop),
    .out_tri_first    (out_tri_first),
    .out_tri_second   (out_tri_second),
    .out_tri_third    (out_tri_third),
    .out_trigram_valid(out_trigram_valid),
    .out_end_of_buffer(out_end_of_buffer),
    .out_unique_count (out_unique_count),
    .out_empty        (out_empty),
    .out_pop          (out_pop)
  );

endmodule

>>> rtl/ute_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ute_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ute_front.sv
// Front end: case folding, trigram window and map index of each accepted byte.
module ute_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [ute_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                      in_first_of_buffer,
  input  logic                      in_last_of_buffer,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic                      q_full,
  output logic                      q_push,
  output ute_pkg::mid_item_t        q_item
);
  import ute_pkg::*;

  logic [BYTE_W-1:0] p0_r, p1_r, p0_nxt, p1_nxt;
  logic [1:0]        seen_r, seen_nxt;
  logic [BYTE_W-1:0] c, p0, p1;
  logic [1:0]        seen;
  logic              accept;
  logic              cand;
  logic [IDX_W-1:0]  idx;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  always_comb begin
    c    = fold_case(in_data_byte);
    p0   = in_first_of_buffer ? '0 : p0_r;
    p1   = in_first_of_buffer ? '0 : p1_r;
    seen = in_first_of_buffer ? 2'd0 : seen_r;
    cand = (seen == 2'd2) && is_printable(p0) && is_printable(p1) && is_printable(c);
    idx  = IDX_W'(digit_of(p0)) * IDX_W'(ALPHABET_SIZE * ALPHABET_SIZE)
         + IDX_W'(digit_of(p1)) * IDX_W'(ALPHABET_SIZE)
         + IDX_W'(digit_of(c));

    q_item.idx   = cand ? idx : '0;
    q_item.t0    = p0[CHAR_W-1:0];
    q_item.t1    = p1[CHAR_W-1:0];
    q_item.t2    = c[CHAR_W-1:0];
    q_item.cand  = cand;
    q_item.first = in_first_of_buffer;
    q_item.last  = in_last_of_buffer;
    q_push = accept && (cand || in_first_of_buffer || in_last_of_buffer);

    p0_nxt   = p0_r;
    p1_nxt   = p1_r;
    seen_nxt = seen_r;
    if (accept) begin
      p0_nxt   = p1;
      p1_nxt   = c;
      seen_nxt = (seen == 2'd2) ? seen : seen + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r   <= '0;
      p1_r   <= '0;
      seen_r <= '0;
    end else begin
      p0_r   <= p0_nxt;
      p1_r   <= p1_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

>>> rtl/ute_mid_queue.sv
// Short queue of classified bytes between the front end and the map stage.
module ute_mid_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ute_pkg::mid_item_t item_in,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output ute_pkg::mid_item_t head
);
  import ute_pkg::*;

  mid_item_t             mem_r [MID_DEPTH];
  logic [MQ_PTR_W-1:0]   wp_r, rp_r, wp_nxt, rp_nxt;
  logic [MQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign full       = (cnt_r == MQ_CNT_W'(MID_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wp_nxt  = do_push ? wp_r + MQ_PTR_W'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + MQ_PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + MQ_CNT_W'(do_push) - MQ_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= item_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/ute_back.sv
// Back end: seen-map test-and-set with epoch tags, unique count and result queue.
module ute_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        head_valid,
  input  ute_pkg::mid_item_t          head,
  output logic                        head_pop,
  output logic [ute_pkg::CHAR_W-1:0]  out_tri_first,
  output logic [ute_pkg::CHAR_W-1:0]  out_tri_second,
  output logic [ute_pkg::CHAR_W-1:0]  out_tri_third,
  output logic                        out_trigram_valid,
  output logic                        out_end_of_buffer,
  output logic [ute_pkg::COUNT_W-1:0] out_unique_count,
  output logic                        out_empty,
  input  logic                        out_pop
);
  import ute_pkg::*;

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_CLEAR = 1'b1;

  logic                 state_r, state_nxt;
  logic [WADDR_W-1:0]   sweep_r, sweep_nxt;
  logic [EP_W-1:0]      epoch_r, epoch_nxt;
  logic                 s1_valid_r, s1_valid_nxt;
  mid_item_t            s1_item_r;
  logic [EP_W-1:0]      s1_ep_r;
  logic                 fwd_valid_r, fwd_valid_nxt;
  logic [WADDR_W-1:0]   fwd_addr_r;
  logic [ENTRY_W-1:0]   fwd_entry_r;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  out_item_t            oq_mem_r [OUT_DEPTH];
  logic [OQ_PTR_W-1:0]  oq_wp_r, oq_rp_r, oq_wp_nxt, oq_rp_nxt;
  logic [OQ_CNT_W-1:0]  oq_cnt_r, oq_cnt_nxt;

  logic                 room, wrap_need, issue, start_wrap;
  logic                 ram_we;
  logic [WADDR_W-1:0]   ram_waddr, ram_raddr, s1_addr;
  logic [ENTRY_W-1:0]   ram_wdata, ram_rdata, entry;
  logic [BIT_W-1:0]     s1_bit;
  logic [WORD_BITS-1:0] live, mask;
  logic                 fresh, oq_push, oq_pop;
  logic [COUNT_W-1:0]   count_base;
  out_item_t            res;
  out_item_t            oq_head;

  ute_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    room       = (oq_cnt_r + OQ_CNT_W'(s1_valid_r)) < OQ_CNT_W'(OUT_DEPTH);
    wrap_need  = head.first && (epoch_r == EP_LAST);
    issue      = (state_r == ST_RUN) && head_valid && room && !wrap_need;
    start_wrap = (state_r == ST_RUN) && head_valid && wrap_need && !s1_valid_r;
    head_pop   = issue;
    ram_raddr  = WADDR_W'(head.idx[IDX_W-1:BIT_W]);

    s1_addr = WADDR_W'(s1_item_r.idx[IDX_W-1:BIT_W]);
    s1_bit  = s1_item_r.idx[BIT_W-1:0];
    entry   = (fwd_valid_r && fwd_addr_r == s1_addr) ? fwd_entry_r : ram_rdata;
    live    = (entry[ENTRY_W-1:WORD_BITS] == s1_ep_r) ? entry[WORD_BITS-1:0] : '0;
    mask    = WORD_BITS'(1) << s1_bit;
    fresh   = s1_valid_r && s1_item_r.cand && ((live & mask) == '0);

    count_base = s1_item_r.first ? '0 : count_r;
    count_nxt  = s1_valid_r ? count_base + COUNT_W'(fresh) : count_r;

    res.t0    = fresh ? s1_item_r.t0 : '0;
    res.t1    = fresh ? s1_item_r.t1 : '0;
    res.t2    = fresh ? s1_item_r.t2 : '0;
    res.valid = fresh;
    res.eob   = s1_item_r.last;
    res.count = count_nxt;
    oq_push   = s1_valid_r && (fresh || s1_item_r.last);

    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_r;
      ram_wdata = {EP_CLEAN, {WORD_BITS{1'b0}}};
    end else begin
      ram_we    = fresh;
      ram_waddr = s1_addr;
      ram_wdata = {s1_ep_r, live | mask};
    end

    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    epoch_nxt     = epoch_r;
    fwd_valid_nxt = fwd_valid_r;
    case (state_r)
      ST_CLEAR: begin
        sweep_nxt = sweep_r + WADDR_W'(1);
        if (sweep_r == WADDR_W'(WORDS - 1)) begin
          state_nxt = ST_RUN;
          sweep_nxt = '0;
          epoch_nxt = '0;
        end
      end
      ST_RUN: begin
        if (fresh) fwd_valid_nxt = 1'b1;
        if (issue && head.first) epoch_nxt = epoch_r + EP_W'(1);
        if (start_wrap) begin
          state_nxt     = ST_CLEAR;
          fwd_valid_nxt = 1'b0;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
    s1_valid_nxt = issue;

    oq_head    = oq_mem_r[oq_rp_r];
    out_empty  = (oq_cnt_r == '0);
    oq_pop     = out_pop && !out_empty;
    oq_wp_nxt  = oq_push ? oq_wp_r + OQ_PTR_W'(1) : oq_wp_r;
    oq_rp_nxt  = oq_pop ? oq_rp_r + OQ_PTR_W'(1) : oq_rp_r;
    oq_cnt_nxt = oq_cnt_r + OQ_CNT_W'(oq_push) - OQ_CNT_W'(oq_pop);
  end

  assign out_tri_first     = oq_head.t0;
  assign out_tri_second    = oq_head.t1;
  assign out_tri_third     = oq_head.t2;
  assign out_trigram_valid = oq_head.valid;
  assign out_end_of_buffer = oq_head.eob;
  assign out_unique_count  = oq_head.count;

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_item_r <= head;
      s1_ep_r   <= head.first ? epoch_r + EP_W'(1) : epoch_r;
    end
    if (fresh) begin
      fwd_addr_r  <= s1_addr;
      fwd_entry_r <= ram_wdata;
    end
    if (oq_push) oq_mem_r[oq_wp_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sweep_r     <= '0;
      epoch_r     <= '0;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      count_r     <= '0;
      oq_wp_r     <= '0;
      oq_rp_r     <= '0;
      oq_cnt_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      epoch_r     <= epoch_nxt;
      s1_valid_r  <= s1_valid_nxt;
      fwd_valid_r <= fwd_valid_nxt;
      count_r     <= count_nxt;
      oq_wp_r     <= oq_wp_nxt;
      oq_rp_r     <= oq_rp_nxt;
      oq_cnt_r    <= oq_cnt_nxt;
    end
  end

endmodule
